[rtl/core/srn16_pkg.sv]
// Package: shared constants and types for the sorted radix node table.
`timescale 1ns / 1ps
package srn16_pkg;
  localparam int Capacity = 16;
  localparam int MaxOut = 16;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_LOOKUP = 3'd1;
  localparam logic [2:0] CMD_CHANGE = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_ANY    = 3'd4;
  localparam logic [2:0] CMD_RANGE  = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_SHRINK   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  key;
    logic [7:0]  end_key;
    logic [63:0] child_in;
    logic        force_req;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  key_out;
    logic [63:0] child_out;
    logic [4:0]  entry_count;
    logic        last;
  } rsp_t;
endpackage

[rtl/core/srn16_if.sv]
// Interface: valid/ready channel carrying one word of a given payload type.
`timescale 1ns / 1ps
interface srn16_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/srn16_front.sv]
// Front: accepts command words into a two-entry queue.
`timescale 1ns / 1ps
module srn16_front import srn16_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic q_valid,
  input  logic q_pop,
  output req_t q_data
);
  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_data;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 2'd0) else $error("queue underflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("count range");
endmodule

[rtl/core/srn16_back.sv]
// Back: table storage and command execution, range emitted one entry a cycle while the output is not stalled.
`timescale 1ns / 1ps
module srn16_back import srn16_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [4:0] shrink_limit,
  input  logic       q_valid,
  output logic       q_pop,
  input  req_t       q_data,
  output logic       out_valid,
  input  logic       out_ready,
  output rsp_t       out_data
);
  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_RANGE} state_t;

  logic [7:0]      key_r [Capacity];
  logic [63:0]     child_r [Capacity];
  logic [CntW-1:0] used_r;
  state_t          state_r, state_nxt;
  req_t            cur_r;
  logic [IdxW-1:0] pos_r, end_r;
  logic            ovalid_r, ovalid_nxt;
  rsp_t            rsp_r, rsp_nxt;

  logic [Capacity-1:0] gt_v, eq_v, eqe_v, leaf_v, inb_v;
  logic [IdxW-1:0] ins_p, fnd_p, end_p, leaf_p;
  logic            ins_hit, fnd_hit, end_hit, leaf_hit;
  logic            room;
  logic [IdxW-1:0] rng_sp, rng_ep;
  logic            rng_go;
  logic            shrink_blk;
  logic            exec_fire, rng_fire;

  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      inb_v[i]  = (CntW'(i) < used_r);
      gt_v[i]   = inb_v[i] && (key_r[i] > cur_r.key);
      eq_v[i]   = inb_v[i] && (key_r[i] == cur_r.key);
      eqe_v[i]  = inb_v[i] && (key_r[i] == cur_r.end_key);
      leaf_v[i] = inb_v[i] && child_r[i][63];
    end
    ins_p = used_r[IdxW-1:0]; ins_hit = 1'b0;
    fnd_p = '0; fnd_hit = 1'b0;
    end_p = '0; end_hit = 1'b0;
    leaf_p = '0; leaf_hit = 1'b0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (gt_v[i]) begin ins_p = IdxW'(i); ins_hit = 1'b1; end
      if (eq_v[i]) begin fnd_p = IdxW'(i); fnd_hit = 1'b1; end
      if (eqe_v[i]) begin end_p = IdxW'(i); end_hit = 1'b1; end
      if (leaf_v[i]) begin leaf_p = IdxW'(i); leaf_hit = 1'b1; end
    end
  end

  assign room       = (used_r < CntW'(Capacity));
  assign out_valid  = ovalid_r;
  assign out_data   = rsp_r;
  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign exec_fire  = (state_r == S_EXEC) && (!ovalid_r || out_ready);
  assign rng_fire   = (state_r == S_RANGE) && (!ovalid_r || out_ready);
  assign shrink_blk = (5'(used_r) == shrink_limit) && !cur_r.force_req;

  // missing start key -> first entry, missing end key -> last entry
  assign rng_sp = fnd_hit ? fnd_p : '0;
  assign rng_ep = end_hit ? end_p : IdxW'(used_r - 1'b1);
  assign rng_go = (used_r != '0) && (rng_sp <= rng_ep);

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r && !out_ready;
    rsp_nxt    = rsp_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt          = 1'b1;
          state_nxt           = S_IDLE;
          rsp_nxt.last        = 1'b1;
          rsp_nxt.key_out     = cur_r.key;
          rsp_nxt.child_out   = '0;
          rsp_nxt.status      = ST_NOTFOUND;
          rsp_nxt.entry_count = 5'(used_r);
          case (cur_r.cmd)
            CMD_INSERT: begin
              rsp_nxt.child_out = cur_r.child_in;
              if (!room) begin
                rsp_nxt.status = ST_FULL;
              end else begin
                rsp_nxt.status      = ST_OK;
                rsp_nxt.entry_count = 5'(used_r + 1'b1);
              end
            end
            CMD_LOOKUP: begin
              if (fnd_hit) begin
                rsp_nxt.status    = ST_OK;
                rsp_nxt.child_out = child_r[fnd_p];
              end
            end
            CMD_CHANGE: begin
              if (fnd_hit) begin
                rsp_nxt.status    = ST_OK;
                rsp_nxt.child_out = cur_r.child_in;
              end
            end
            CMD_REMOVE: begin
              // shrink guard wins over the search
              if (shrink_blk) begin
                rsp_nxt.status = ST_SHRINK;
              end else if (fnd_hit) begin
                rsp_nxt.status      = ST_OK;
                rsp_nxt.child_out   = child_r[fnd_p];
                rsp_nxt.entry_count = 5'(used_r - 1'b1);
              end
            end
            CMD_ANY: begin
              if (used_r == '0) begin
                rsp_nxt.status  = ST_EMPTY;
                rsp_nxt.key_out = '0;
              end else begin
                rsp_nxt.status    = ST_OK;
                rsp_nxt.key_out   = key_r[leaf_hit ? leaf_p : '0];
                rsp_nxt.child_out = child_r[leaf_hit ? leaf_p : '0];
              end
            end
            CMD_RANGE: begin
              rsp_nxt.status  = ST_EMPTY;
              rsp_nxt.key_out = '0;
              if (rng_go) begin
                ovalid_nxt = 1'b0;
                state_nxt  = S_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      S_RANGE: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt          = 1'b1;
          rsp_nxt.status      = ST_OK;
          rsp_nxt.key_out     = key_r[pos_r];
          rsp_nxt.child_out   = child_r[pos_r];
          rsp_nxt.entry_count = 5'(used_r);
          rsp_nxt.last        = (pos_r == end_r);
          if (pos_r == end_r) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      used_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      rsp_r    <= rsp_nxt;
      if (q_pop) cur_r <= q_data;
      if (exec_fire) begin
        case (cur_r.cmd)
          CMD_INSERT: begin
            if (room) begin
              for (int i = Capacity - 1; i > 0; i--) begin
                if (IdxW'(i) > ins_p && inb_v[i-1]) begin
                  key_r[i]   <= key_r[i-1];
                  child_r[i] <= child_r[i-1];
                end
              end
              key_r[ins_p]   <= cur_r.key;
              child_r[ins_p] <= cur_r.child_in;
              used_r <= used_r + 1'b1;
            end
          end
          CMD_CHANGE: begin
            if (fnd_hit) child_r[fnd_p] <= cur_r.child_in;
          end
          CMD_REMOVE: begin
            if (!shrink_blk && fnd_hit) begin
              for (int i = 0; i < Capacity - 1; i++) begin
                if (IdxW'(i) >= fnd_p) begin
                  key_r[i]   <= key_r[i+1];
                  child_r[i] <= child_r[i+1];
                end
              end
              used_r <= used_r - 1'b1;
            end
          end
          CMD_RANGE: begin
            if (rng_go) begin
              pos_r <= rng_sp;
              end_r <= rng_ep;
            end
          end
          default: ;
        endcase
      end
      if (rng_fire) pos_r <= pos_r + 1'b1;
    end
  end

  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CntW'(Capacity)) else $error("count beyond capacity");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == S_EXEC) else $error("pop without exec");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RANGE |-> pos_r <= end_r) else $error("range overrun");
endmodule

[rtl/core/sorted_radix_node16_table.sv]
// Top level: sorted 16-entry key/child table with queued command front.
// Commands run one at a time: the back's fetch/execute FSM pops a word, executes it
// and registers its result word before it takes the next command; a range command
// instead emits its result words one per cycle while out_ch is not stalled.
// Reset: rst_n synchronous active low; table emptied, shrink_limit = 3.
`timescale 1ns / 1ps
module sorted_radix_node16_table import srn16_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  srn16_if.sink   in_ch,
  srn16_if.source out_ch,
  srn16_if.sink   cfg_ch
);
  logic       q_valid, q_pop;
  req_t       q_data;
  logic [4:0] shrink_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shrink_r <= 5'd3;
    end else if (cfg_ch.valid) begin
      shrink_r <= cfg_ch.data;
    end
  end

  srn16_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid, .q_pop, .q_data
  );

  srn16_back u_back (
    .clk, .rst_n, .shrink_limit(shrink_r),
    .q_valid, .q_pop, .q_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule
